/* sv/hsvrgb_pkg.sv */
// Shared constants and types for the HSV to RGB888 converter.
// No dependencies; imported by hsvrgb_div75, hsv_to_rgb888 and the test bench.
`default_nettype none

package hsvrgb_pkg;

  localparam int HSVRGB_FRAC_BITS = 12;

  // Fixed field widths of the pixel interface
  localparam int HUE_W = 13;
  localparam int SAT_W = 14;
  localparam int CH_W  = 8;

  // Hue geometry in tenths of a degree
  localparam int HUE_FULL      = 3600;
  localparam int SECTOR_TENTHS = 600;
  localparam int HC_W          = 12;  // clamped hue 0..3599
  localparam int POS_W         = 10;  // position 0..600

  // Divide by 75 through a reciprocal multiply
  localparam int DIVISOR   = 75;
  localparam int DIV_SHIFT = 21;
  localparam int DIV_MULT  = (1 << DIV_SHIFT) / DIVISOR;
  localparam int DIV_M_W   = 15;

  typedef enum logic [2:0] {
    SECT_RED_YEL = 3'd0,
    SECT_YEL_GRN = 3'd1,
    SECT_GRN_CYN = 3'd2,
    SECT_CYN_BLU = 3'd3,
    SECT_BLU_MAG = 3'd4,
    SECT_MAG_RED = 3'd5
  } sector_t;

endpackage

`default_nettype wire

/* sv/hsvrgb_div75.sv */
// Constant divide by 75: reciprocal multiply into a register, then one
// compare-and-increment correction. Depends on hsvrgb_pkg.
`default_nettype none

module hsvrgb_div75
  import hsvrgb_pkg::*;
#(
  parameter int QW = 17
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [QW-1:0]   dividend,
  output logic      [CH_W-1:0] quotient
);

  localparam int PW = QW + DIV_M_W;
  localparam int EW = PW - DIV_SHIFT;

  logic [PW-1:0] prod;
  logic [EW-1:0] est_r;
  logic [EW-1:0] est_nxt;
  logic [QW-1:0] q_r;
  logic [QW+7:0] est_x75;
  logic [QW+7:0] rem;

  assign prod    = PW'(dividend) * PW'(DIV_MULT);
  assign est_nxt = prod[PW-1:DIV_SHIFT];

  always_ff @(posedge clk) begin
    if (en) begin
      est_r <= est_nxt;
      q_r   <= dividend;
    end
  end

  // estimate is exact or one low; bump it when the remainder overflows
  assign est_x75 = (QW+8)'(est_r) * (QW+8)'(DIVISOR);
  assign rem     = (QW+8)'(q_r) - est_x75;

  always_comb begin
    if (rem >= (QW+8)'(DIVISOR)) begin
      quotient = CH_W'(est_r + EW'(1));
    end else begin
      quotient = CH_W'(est_r);
    end
  end

endmodule

`default_nettype wire

/* sv/hsv_to_rgb888.sv */
// Top level of the HSV to RGB888 converter: six-stage pipeline.
// Depends on hsvrgb_pkg and hsvrgb_div75.
//
//   channel  ports                                   role
//   in_      in_valid/in_ready, hue/saturation/brightness   pixel in
//   out_     out_valid/out_ready, red/green/blue     pixel out
//
// One transaction in and one out per cycle when out_ready does not stall; out_valid
// follows the accepting edge through six register stages, a depth set by the multiply
// chain for the middle channel and the divide by 75 that finishes its rounding.
// Reset clears only the stage valid bits; the data registers are not reset.
// A stall on out_ready freezes every stage; in_ready stays high while the
// output register is empty or being drained.
`default_nettype none

module hsv_to_rgb888
  import hsvrgb_pkg::*;
#(
  parameter int FRAC_BITS = HSVRGB_FRAC_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [HUE_W-1:0] in_hue,
  input  wire logic [SAT_W-1:0] in_saturation,
  input  wire logic [SAT_W-1:0] in_brightness,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [CH_W-1:0]  out_red,
  output logic      [CH_W-1:0]  out_green,
  output logic      [CH_W-1:0]  out_blue
);

  localparam int ONE = 1 << FRAC_BITS;
  localparam int SW  = FRAC_BITS + 1;           // clamped s, v
  localparam int AW  = SW + POS_W;              // s * k
  localparam int LW  = 2 * SW;                  // v * (1 - s)
  localparam int WW  = FRAC_BITS + POS_W;       // 600*1.0 - s*k
  localparam int TW  = SW + WW;                 // v * w
  localparam int NW  = TW + 9;                  // 255*t + half
  localparam int QSH = 2 * FRAC_BITS + 3;
  localparam int QW  = NW - QSH;
  localparam int HW  = SW + 9;
  localparam int LSW = LW + 9;

  logic adv;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  // ---------------- stage 1: clamp, sector, position
  logic [31:0]       sat_mag, bri_mag;
  logic [SW-1:0]     s_nxt, v_nxt;
  logic [HC_W-1:0]   h_c;
  sector_t           sect_nxt;
  logic [HC_W-1:0]   base;
  logic [POS_W-1:0]  pos_raw, k_nxt;

  assign sat_mag = 32'(in_saturation[SAT_W-2:0]);
  assign bri_mag = 32'(in_brightness[SAT_W-2:0]);

  always_comb begin
    if (in_saturation[SAT_W-1]) begin
      s_nxt = '0;
    end else if (sat_mag > 32'(ONE)) begin
      s_nxt = SW'(ONE);
    end else begin
      s_nxt = SW'(sat_mag);
    end
    if (in_brightness[SAT_W-1]) begin
      v_nxt = '0;
    end else if (bri_mag > 32'(ONE)) begin
      v_nxt = SW'(ONE);
    end else begin
      v_nxt = SW'(bri_mag);
    end
  end

  // negative hue, and full circle and above, map to red
  always_comb begin
    if (in_hue[HUE_W-1] || (in_hue >= HUE_W'(HUE_FULL))) begin
      h_c = '0;
    end else begin
      h_c = in_hue[HC_W-1:0];
    end
  end

  always_comb begin
    if (h_c >= HC_W'(5 * SECTOR_TENTHS)) begin
      sect_nxt = SECT_MAG_RED;
    end else if (h_c >= HC_W'(4 * SECTOR_TENTHS)) begin
      sect_nxt = SECT_BLU_MAG;
    end else if (h_c >= HC_W'(3 * SECTOR_TENTHS)) begin
      sect_nxt = SECT_CYN_BLU;
    end else if (h_c >= HC_W'(2 * SECTOR_TENTHS)) begin
      sect_nxt = SECT_GRN_CYN;
    end else if (h_c >= HC_W'(SECTOR_TENTHS)) begin
      sect_nxt = SECT_YEL_GRN;
    end else begin
      sect_nxt = SECT_RED_YEL;
    end
  end

  always_comb begin
    case (sect_nxt)
      SECT_RED_YEL: base = '0;
      SECT_YEL_GRN: base = HC_W'(SECTOR_TENTHS);
      SECT_GRN_CYN: base = HC_W'(2 * SECTOR_TENTHS);
      SECT_CYN_BLU: base = HC_W'(3 * SECTOR_TENTHS);
      SECT_BLU_MAG: base = HC_W'(4 * SECTOR_TENTHS);
      default:      base = HC_W'(5 * SECTOR_TENTHS);
    endcase
  end

  assign pos_raw = POS_W'(h_c - base);
  // k = 600 - position within sector; odd sectors run backwards
  assign k_nxt   = sect_nxt[0] ? pos_raw : POS_W'(SECTOR_TENTHS) - pos_raw;

  logic [SW-1:0]    s1_r, v1d_r;
  logic [POS_W-1:0] k1_r;
  sector_t          sect1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r    <= s_nxt;
      v1d_r   <= v_nxt;
      k1_r    <= k_nxt;
      sect1_r <= sect_nxt;
    end
  end

  // ---------------- stage 2: s*k, v*(1-s), top channel
  logic [AW-1:0] a_nxt;
  logic [LW-1:0] lp_nxt;
  logic [HW-1:0] hi_sum;

  assign a_nxt  = AW'(s1_r) * AW'(k1_r);
  assign lp_nxt = LW'(v1d_r) * LW'(SW'(ONE) - s1_r);
  assign hi_sum = (HW'(v1d_r) << 8) - HW'(v1d_r) + (HW'(1) << (FRAC_BITS - 1));

  logic [AW-1:0]   a2_r;
  logic [LW-1:0]   lp2_r;
  logic [SW-1:0]   v2d_r;
  logic [CH_W-1:0] hi2_r;
  sector_t         sect2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      a2_r    <= a_nxt;
      lp2_r   <= lp_nxt;
      v2d_r   <= v1d_r;
      hi2_r   <= hi_sum[FRAC_BITS +: CH_W];
      sect2_r <= sect1_r;
    end
  end

  // ---------------- stage 3: t = v*(600*1.0 - s*k), bottom channel
  logic [WW-1:0]  w_val;
  logic [TW-1:0]  t_nxt;
  logic [LSW-1:0] lo_sum;

  assign w_val  = WW'(AW'(SECTOR_TENTHS * ONE) - a2_r);
  assign t_nxt  = TW'(v2d_r) * TW'(w_val);
  assign lo_sum = (LSW'(lp2_r) << 8) - LSW'(lp2_r) + (LSW'(1) << (2 * FRAC_BITS - 1));

  logic [TW-1:0]   t3_r;
  logic [CH_W-1:0] lo3_r, hi3_r;
  sector_t         sect3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      t3_r    <= t_nxt;
      lo3_r   <= lo_sum[2 * FRAC_BITS +: CH_W];
      hi3_r   <= hi2_r;
      sect3_r <= sect2_r;
    end
  end

  // ---------------- stage 4: scale by 255, add half, drop 2F+3 bits
  logic [NW-1:0] n_sum;

  assign n_sum = (NW'(t3_r) << 8) - NW'(t3_r)
               + (NW'(SECTOR_TENTHS / 2) << (2 * FRAC_BITS));

  logic [QW-1:0]   q4_r;
  logic [CH_W-1:0] lo4_r, hi4_r, lo5_r, hi5_r;
  sector_t         sect4_r, sect5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      q4_r    <= n_sum[NW-1:QSH];
      lo4_r   <= lo3_r;
      hi4_r   <= hi3_r;
      sect4_r <= sect3_r;
      lo5_r   <= lo4_r;
      hi5_r   <= hi4_r;
      sect5_r <= sect4_r;
    end
  end

  // ---------------- stage 5: divide by 75 finishes the middle channel
  logic [CH_W-1:0] mid5;

  hsvrgb_div75 #(
    .QW (QW)
  ) u_div75 (
    .clk      (clk),
    .en       (adv),
    .dividend (q4_r),
    .quotient (mid5)
  );

  // ---------------- stage 6: route channels by sector
  logic [CH_W-1:0] r_nxt, g_nxt, b_nxt;

  always_comb begin
    case (sect5_r)
      SECT_RED_YEL: begin r_nxt = hi5_r; g_nxt = mid5;  b_nxt = lo5_r; end
      SECT_YEL_GRN: begin r_nxt = mid5;  g_nxt = hi5_r; b_nxt = lo5_r; end
      SECT_GRN_CYN: begin r_nxt = lo5_r; g_nxt = hi5_r; b_nxt = mid5;  end
      SECT_CYN_BLU: begin r_nxt = lo5_r; g_nxt = mid5;  b_nxt = hi5_r; end
      SECT_BLU_MAG: begin r_nxt = mid5;  g_nxt = lo5_r; b_nxt = hi5_r; end
      default:      begin r_nxt = hi5_r; g_nxt = lo5_r; b_nxt = mid5;  end
    endcase
  end

  logic [CH_W-1:0] red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      red_r   <= r_nxt;
      green_r <= g_nxt;
      blue_r  <= b_nxt;
    end
  end

  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

`default_nettype wire

/* test/hsv_to_rgb888_test.sv */
// Self-checking bench for hsv_to_rgb888: directed and random HSV pixels under random
// backpressure, each compared with an in-bench integer model of the conversion.
// Depends on hsvrgb_pkg and hsv_to_rgb888.

module hsv_to_rgb888_test
  import hsvrgb_pkg::*;
();

  localparam longint unsigned UNIT = 64'd1 << HSVRGB_FRAC_BITS;
  localparam int RANDOM_PIXELS = 1400;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [SAT_W-1:0] bri;
  } hsv_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [HUE_W-1:0] in_hue = '0;
  logic [SAT_W-1:0] in_saturation = '0;
  logic [SAT_W-1:0] in_brightness = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [CH_W-1:0]  out_red;
  logic [CH_W-1:0]  out_green;
  logic [CH_W-1:0]  out_blue;

  hsv_t pix_pending[$];
  rgb_t rgb_expected[$];
  hsv_t next_pix;
  rgb_t got, want;
  int   pix_total = 0;
  int   pix_offered = 0;
  int   pix_accepted = 0;
  int   err_count = 0;
  int   quiet_cycles = 0;

  hsv_to_rgb888 dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_hue       (in_hue),
    .in_saturation(in_saturation),
    .in_brightness(in_brightness),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue)
  );

  always #2 clk = ~clk;

  // Scale a level held over the common denominator to 0..255, rounding half up.
  function automatic logic [CH_W-1:0] level_to_byte(longint unsigned num);
    longint unsigned full;
    full = UNIT * UNIT * SECTOR_TENTHS;
    return CH_W'((num * 255 + full / 2) / full);
  endfunction

  function automatic rgb_t convert_pixel(hsv_t px);
    int h, s, v, pos;
    longint unsigned cn, mn, xn;
    logic [CH_W-1:0] top, mid, bot;
    sector_t sect;
    rgb_t res;
    h = $signed(px.hue);
    s = $signed(px.sat);
    v = $signed(px.bri);
    h = (h < 0) ? 0 : (h > HUE_FULL) ? HUE_FULL : h;
    s = (s < 0) ? 0 : (s > int'(UNIT)) ? int'(UNIT) : s;
    v = (v < 0) ? 0 : (v > int'(UNIT)) ? int'(UNIT) : v;
    // full circle wraps back to red
    if (h == HUE_FULL) h = 0;
    sect = sector_t'(h / SECTOR_TENTHS);
    pos = h % SECTOR_TENTHS;
    if (sect[0]) pos = SECTOR_TENTHS - pos;
    cn = longint'(v) * longint'(s) * SECTOR_TENTHS;
    mn = longint'(v) * (longint'(UNIT) - longint'(s)) * SECTOR_TENTHS;
    xn = longint'(v) * longint'(s) * longint'(pos);
    top = level_to_byte(cn + mn);
    mid = level_to_byte(xn + mn);
    bot = level_to_byte(mn);
    case (sect)
      SECT_RED_YEL: res = '{top, mid, bot};
      SECT_YEL_GRN: res = '{mid, top, bot};
      SECT_GRN_CYN: res = '{bot, top, mid};
      SECT_CYN_BLU: res = '{bot, mid, top};
      SECT_BLU_MAG: res = '{mid, bot, top};
      default:      res = '{top, bot, mid};
    endcase
    return res;
  endfunction

  // Idle rate for one side, by which third of the run the count falls in.
  function automatic int idle_pct(int n, bit sender);
    if (n < pix_total / 3) return sender ? 24 : 56;
    if (n < 2 * pix_total / 3) return sender ? 56 : 24;
    return 0;
  endfunction

  task automatic add_pixel(int h, int s, int v);
    hsv_t px;
    px.hue = h[HUE_W-1:0];
    px.sat = s[SAT_W-1:0];
    px.bri = v[SAT_W-1:0];
    pix_pending.push_back(px);
  endtask

  // Sender: hold the transaction until taken, then load the next or idle.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (pix_accepted == pix_offered) begin
      if (pix_pending.size() > 0 &&
          $urandom_range(0, 99) >= idle_pct(pix_offered, 1'b1)) begin
        next_pix = pix_pending.pop_front();
        in_valid <= 1'b1;
        in_hue <= next_pix.hue;
        in_saturation <= next_pix.sat;
        in_brightness <= next_pix.bri;
        pix_offered++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(0, 99) >= idle_pct(pix_accepted, 1'b0));
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      rgb_expected.push_back(convert_pixel('{in_hue, in_saturation, in_brightness}));
      pix_accepted++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got = '{out_red, out_green, out_blue};
      if (rgb_expected.size() == 0) begin
        $display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $time,
                 got.red, got.green, got.blue);
        err_count++;
      end else begin
        want = rgb_expected.pop_front();
        if (got !== want) begin
          $display("%0t: pixel mismatch expected r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                   $time, want.red, want.green, want.blue, got.red, got.green, got.blue);
          err_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int i, mode, h, s, v;
    // primaries and secondaries at full saturation and brightness
    for (i = 0; i <= 6; i++) add_pixel(i * SECTOR_TENTHS, 4096, 4096);
    add_pixel(3599, 4096, 4096);
    add_pixel(4095, 4096, 4096);
    add_pixel(-1, 4096, 4096);
    add_pixel(-4096, 4096, 4096);
    add_pixel(300, 4096, 4096);
    add_pixel(900, 2048, 4096);
    add_pixel(1500, 4096, 2048);
    add_pixel(2100, 8191, 8191);
    add_pixel(2700, -8192, 4096);
    add_pixel(3300, 4096, -8192);
    add_pixel(450, 0, 4096);
    add_pixel(0, 4096, 0);
    add_pixel(1000, 4097, 4097);
    add_pixel(3599, 1, 1);
    add_pixel(2000, 4095, 4095);
    add_pixel(100, 2048, 1);

    for (i = 0; i < RANDOM_PIXELS; i++) begin
      mode = $urandom_range(0, 9);
      if (mode < 7) begin
        h = $urandom_range(0, HUE_FULL);
        s = $urandom_range(0, 4096);
        v = $urandom_range(0, 4096);
      end else if (mode == 7) begin
        // near sector edges, saturation at the ends of the level range, brightness near the top or anywhere
        h = SECTOR_TENTHS * $urandom_range(0, 6) + $urandom_range(0, 2) - 1;
        s = $urandom_range(0, 1) ? 4095 + $urandom_range(0, 2) : $urandom_range(0, 1);
        v = $urandom_range(0, 1) ? 4095 + $urandom_range(0, 2) : $urandom_range(0, 4096);
      end else begin
        h = $urandom;
        s = $urandom;
        v = $urandom;
      end
      add_pixel(h, s, v);
    end
    pix_total = pix_pending.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pix_pending.size() > 0 || pix_accepted != pix_offered ||
           rgb_expected.size() > 0)
      @(posedge clk);
    // catch any stray pixel still in the pipeline
    repeat (16) @(posedge clk);

    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/hsvrgb_pkg.sv
sv/hsvrgb_div75.sv
sv/hsv_to_rgb888.sv
test/hsv_to_rgb888_test.sv
